>>> sv/ape_pkg.sv
package ape_pkg;

    // Width of the per-port microsecond counter.
    localparam int TIMER_WIDTH = 8;
    // Compare width covers both the 8-bit positions and the counter.
    localparam int CMP_WIDTH = (TIMER_WIDTH > 8) ? TIMER_WIDTH : 8;
    localparam int POS_WIDTH = 8;

    localparam logic [POS_WIDTH-1:0] POS_RESET = 8'd41;
    localparam logic [POS_WIDTH-1:0] MIN_RESET = 8'd20;
    localparam logic [POS_WIDTH-1:0] MAX_RESET = 8'd53;

    // Configuration register indexes.
    localparam logic REG_POS_MIN = 1'b0;
    localparam logic REG_POS_MAX = 1'b1;

    // Item kinds.
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    // What one port lane reports for the current item.
    typedef struct packed {
        logic                 line_x;
        logic                 line_y;
        logic [POS_WIDTH-1:0] pos_x;
        logic [POS_WIDTH-1:0] pos_y;
    } lane_res_t;

    // One full result item, both ports.
    typedef struct packed {
        lane_res_t port_a;
        lane_res_t port_b;
    } result_t;

    // One step up or down, then clamp to the configured window. The step is
    // done two bits wider and signed so it cannot wrap before the clamp.
    function automatic logic [POS_WIDTH-1:0] step_clamp(
        input logic [POS_WIDTH-1:0] pos,
        input logic                 up,
        input logic                 down,
        input logic [POS_WIDTH-1:0] lo,
        input logic [POS_WIDTH-1:0] hi
    );
        logic signed [POS_WIDTH+1:0] v;
        logic signed [POS_WIDTH+1:0] lo_s;
        logic signed [POS_WIDTH+1:0] hi_s;
        logic [POS_WIDTH-1:0]        r;
        v    = signed'({2'b00, pos}) + signed'({{(POS_WIDTH+1){1'b0}}, up})
               - signed'({{(POS_WIDTH+1){1'b0}}, down});
        lo_s = signed'({2'b00, lo});
        hi_s = signed'({2'b00, hi});
        if (v < lo_s) begin
            r = lo;
        end else if (v > hi_s) begin
            r = hi;
        end else begin
            r = v[POS_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

>>> sv/ape_lane.sv
module ape_lane
    import ape_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 kind,
    input  logic [3:0]           dirs,
    input  logic                 sense,
    input  logic [POS_WIDTH-1:0] pos_min,
    input  logic [POS_WIDTH-1:0] pos_max,
    output lane_res_t            res
);

    logic [POS_WIDTH-1:0]   pos_x_reg, pos_x_next;
    logic [POS_WIDTH-1:0]   pos_y_reg, pos_y_next;
    logic [POS_WIDTH-1:0]   cmp_x_reg, cmp_x_next;
    logic [POS_WIDTH-1:0]   cmp_y_reg, cmp_y_next;
    logic [TIMER_WIDTH-1:0] cnt_reg, cnt_next;
    logic                   run_reg, run_next;
    logic                   line_x_reg, line_x_next;
    logic                   line_y_reg, line_y_next;
    logic                   sense_reg;
    logic                   start;
    logic                   count;
    logic [CMP_WIDTH-1:0]   cnt_ext;

    always_comb
    begin
        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        if (kind == KIND_UPDATE)
        begin
            pos_x_next = step_clamp(pos_x_reg, dirs[0], dirs[1], pos_min, pos_max);
            pos_y_next = step_clamp(pos_y_reg, dirs[2], dirs[3], pos_min, pos_max);
        end

        start = sense_reg && !sense;
        count = (kind == KIND_TICK) && run_reg && !start;

        cmp_x_next  = start ? pos_x_next : cmp_x_reg;
        cmp_y_next  = start ? pos_y_next : cmp_y_reg;
        run_next    = run_reg || start;
        cnt_next    = start ? '0 : (count ? cnt_reg + 1'b1 : cnt_reg);
        cnt_ext     = CMP_WIDTH'(cnt_next);
        line_x_next = line_x_reg;
        line_y_next = line_y_reg;
        if (start)
        begin
            line_x_next = 1'b0;
            line_y_next = 1'b0;
        end
        else if (count)
        begin
            if (cnt_ext == CMP_WIDTH'(cmp_x_reg))
            begin
                line_x_next = 1'b1;
            end
            if (cnt_ext == CMP_WIDTH'(cmp_y_reg))
            begin
                line_y_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg  <= POS_RESET;
            pos_y_reg  <= POS_RESET;
            cmp_x_reg  <= POS_RESET;
            cmp_y_reg  <= POS_RESET;
            cnt_reg    <= '0;
            run_reg    <= 1'b0;
            line_x_reg <= 1'b1;
            line_y_reg <= 1'b1;
            sense_reg  <= 1'b1;
        end
        else if (accept)
        begin
            pos_x_reg  <= pos_x_next;
            pos_y_reg  <= pos_y_next;
            cmp_x_reg  <= cmp_x_next;
            cmp_y_reg  <= cmp_y_next;
            cnt_reg    <= cnt_next;
            run_reg    <= run_next;
            line_x_reg <= line_x_next;
            line_y_reg <= line_y_next;
            sense_reg  <= sense;
        end
    end

    // The result reflects the state after this item.
    assign res.line_x = line_x_next;
    assign res.line_y = line_y_next;
    assign res.pos_x  = pos_x_next;
    assign res.pos_y  = pos_y_next;

    // A falling sense edge restarts the port cleanly.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && start) |=> (cnt_reg == '0 && run_reg && !line_x_reg && !line_y_reg))
        else $error("port did not restart on sense edge");

    // Once high, a line only drops on a new measurement.
    assert property (@(posedge clk) disable iff (!rst_n)
        (line_x_reg && !(accept && start)) |=> line_x_reg)
        else $error("X line dropped without sense edge");

    // An idle counter never advances.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!run_reg && !(accept && start)) |=> $stable(cnt_reg))
        else $error("stopped counter moved");

endmodule

>>> sv/ape_merge.sv
module ape_merge
    import ape_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  lane_res_t res_a,
    input  lane_res_t res_b,
    output logic      out_valid,
    input  logic      out_stall,
    output result_t   out_data
);

    result_t merged;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    logic    accept;
    logic    take;
    logic    load_out;
    logic    load_skid;

    always_comb
    begin
        merged.port_a = res_a;
        merged.port_b = res_b;

        accept = in_valid && !in_stall;
        take   = out_valid_reg && !out_stall;

        // A new item goes straight to the output register when that slot is
        // free or leaving; otherwise it parks in the skid stage.
        load_out  = accept && (!out_valid_reg || take) && !skid_valid_reg;
        load_skid = accept && !load_out;

        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (take)
        begin
            out_valid_next  = skid_valid_reg;
            skid_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        if (load_skid)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= merged;
        end
        else if (take && skid_valid_reg)
        begin
            out_data_reg <= skid_data_reg;
        end
        if (load_skid)
        begin
            skid_data_reg <= merged;
        end
    end

    assign in_stall  = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The skid stage is only ever filled behind a waiting output.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item with empty output");

    // A drained skid item moves forward and leaves the skid stage empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid did not drain");

    // Taking the output with nothing behind it and no new item empties it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !skid_valid_reg && !in_valid) |=> !out_valid_reg)
        else $error("output item repeated");

endmodule

>>> sv/analog_paddle_emulator.sv
// Channel   Handshake                 Payload
// input     in_valid / in_stall       kind, joy_a, joy_b, sense_a, sense_b
// output    out_valid / out_stall     line_{a,b}_{x,y}, position_{a,b}_{x,y}
// config    cfg_we                    cfg_index, cfg_data
//
// Both port lanes compute the new state in the cycle an item is accepted,
// and the result is registered in the output register, or in the skid while
// that waits; one item per cycle is sustained while out_stall stays low.
// Reset is asynchronous and active low; it restores positions and compare
// values to 41, lines high, counters stopped and the window to 20..53.
// A two-entry output stage (output register plus skid) lets the block keep
// accepting while a result waits; in_stall rises only when both are full.
module analog_paddle_emulator
    import ape_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [POS_WIDTH-1:0] cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 kind,
    input  logic [3:0]           joy_a,
    input  logic [3:0]           joy_b,
    input  logic                 sense_a,
    input  logic                 sense_b,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 line_a_x,
    output logic                 line_a_y,
    output logic                 line_b_x,
    output logic                 line_b_y,
    output logic [POS_WIDTH-1:0] position_a_x,
    output logic [POS_WIDTH-1:0] position_a_y,
    output logic [POS_WIDTH-1:0] position_b_x,
    output logic [POS_WIDTH-1:0] position_b_y
);

    logic [POS_WIDTH-1:0] pos_min_reg;
    logic [POS_WIDTH-1:0] pos_max_reg;
    logic                 accept;
    lane_res_t            res_a;
    lane_res_t            res_b;
    result_t              out_data;

    // The user must write the clamp window only while the block is idle; the block does not enforce it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_min_reg <= MIN_RESET;
            pos_max_reg <= MAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_POS_MIN: pos_min_reg <= cfg_data;
                REG_POS_MAX: pos_max_reg <= cfg_data;
                default:     pos_min_reg <= pos_min_reg;
            endcase
        end
    end

    assign accept = in_valid && !in_stall;

    // One lane per paddle port; each owns its positions, timer and lines.
    ape_lane u_lane_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .kind    (kind),
        .dirs    (joy_a),
        .sense   (sense_a),
        .pos_min (pos_min_reg),
        .pos_max (pos_max_reg),
        .res     (res_a)
    );

    ape_lane u_lane_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .kind    (kind),
        .dirs    (joy_b),
        .sense   (sense_b),
        .pos_min (pos_min_reg),
        .pos_max (pos_max_reg),
        .res     (res_b)
    );

    // The merge stage joins both lanes into one result item and buffers it.
    ape_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .res_a     (res_a),
        .res_b     (res_b),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign line_a_x     = out_data.port_a.line_x;
    assign line_a_y     = out_data.port_a.line_y;
    assign line_b_x     = out_data.port_b.line_x;
    assign line_b_y     = out_data.port_b.line_y;
    assign position_a_x = out_data.port_a.pos_x;
    assign position_a_y = out_data.port_a.pos_y;
    assign position_b_x = out_data.port_b.pos_x;
    assign position_b_y = out_data.port_b.pos_y;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps

// Scoreboard for the paddle emulator. It keeps its own copy of the paddle
// state, works out the result of every accepted item and checks the results
// in order.
class paddle_scoreboard;
    logic [ape_pkg::POS_WIDTH-1:0]   pos_lo;
    logic [ape_pkg::POS_WIDTH-1:0]   pos_hi;
    logic [ape_pkg::POS_WIDTH-1:0]   position [4];
    logic [ape_pkg::POS_WIDTH-1:0]   compare_val [4];
    logic [ape_pkg::TIMER_WIDTH-1:0] tick_count [2];
    bit                              running [2];
    bit                              line_level [4];
    bit                              last_sense [2];
    ape_pkg::result_t                expected_q [$];
    int                              errors;

    function new();
        pos_lo = ape_pkg::MIN_RESET;
        pos_hi = ape_pkg::MAX_RESET;
        for (int i = 0; i < 4; i++) begin
            position[i]    = ape_pkg::POS_RESET;
            compare_val[i] = ape_pkg::POS_RESET;
            line_level[i]  = 1'b1;
        end
        for (int p = 0; p < 2; p++) begin
            tick_count[p] = '0;
            running[p]    = 1'b0;
            last_sense[p] = 1'b1;
        end
        errors = 0;
    endfunction

    function void set_window(int lo, int hi);
        pos_lo = lo[ape_pkg::POS_WIDTH-1:0];
        pos_hi = hi[ape_pkg::POS_WIDTH-1:0];
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // The step is taken two bits wider and signed, so nothing wraps before
    // the clamp. The low bound wins over the high bound.
    function logic [ape_pkg::POS_WIDTH-1:0] move_position(
        logic [ape_pkg::POS_WIDTH-1:0] pos, logic up, logic down);
        logic signed [ape_pkg::POS_WIDTH+1:0] v;
        v = $signed({2'b00, pos});
        if (up)
            v = v + 10'sd1;
        if (down)
            v = v - 10'sd1;
        if (v < $signed({2'b00, pos_lo}))
            return pos_lo;
        else if (v > $signed({2'b00, pos_hi}))
            return pos_hi;
        return v[ape_pkg::POS_WIDTH-1:0];
    endfunction

    function void note_item(logic k, logic [3:0] ja, logic [3:0] jb, logic sa, logic sbv);
        logic [3:0]                    joy [2];
        logic                          sense [2];
        bit                            started [2];
        logic [ape_pkg::CMP_WIDTH-1:0] cnt_ext;
        logic [ape_pkg::CMP_WIDTH-1:0] cmp_ext;
        ape_pkg::result_t              r;
        joy[0]   = ja;
        joy[1]   = jb;
        sense[0] = sa;
        sense[1] = sbv;
        if (k == ape_pkg::KIND_UPDATE) begin
            for (int p = 0; p < 2; p++) begin
                position[2*p]   = move_position(position[2*p], joy[p][0], joy[p][1]);
                position[2*p+1] = move_position(position[2*p+1], joy[p][2], joy[p][3]);
            end
        end
        for (int p = 0; p < 2; p++) begin
            started[p] = last_sense[p] && !sense[p];
            if (started[p]) begin
                line_level[2*p]    = 1'b0;
                line_level[2*p+1]  = 1'b0;
                tick_count[p]      = '0;
                running[p]         = 1'b1;
                compare_val[2*p]   = position[2*p];
                compare_val[2*p+1] = position[2*p+1];
            end
            last_sense[p] = sense[p];
        end
        if (k == ape_pkg::KIND_TICK) begin
            for (int p = 0; p < 2; p++) begin
                if (running[p] && !started[p]) begin
                    tick_count[p] = tick_count[p] + 1'b1;
                    for (int i = 2*p; i < 2*p + 2; i++) begin
                        cnt_ext = tick_count[p];
                        cmp_ext = compare_val[i];
                        if (cnt_ext == cmp_ext)
                            line_level[i] = 1'b1;
                    end
                end
            end
        end
        r.port_a.line_x = line_level[0];
        r.port_a.line_y = line_level[1];
        r.port_b.line_x = line_level[2];
        r.port_b.line_y = line_level[3];
        r.port_a.pos_x  = position[0];
        r.port_a.pos_y  = position[1];
        r.port_b.pos_x  = position[2];
        r.port_b.pos_y  = position[3];
        expected_q.push_back(r);
    endfunction

    task report_mismatch(string msg);
        if (errors < 50)
            $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    task check_result(ape_pkg::result_t got);
        ape_pkg::result_t want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result %h arrived with no item outstanding", got));
            return;
        end
        want = expected_q.pop_front();
        if (got.port_a.line_x !== want.port_a.line_x)
            report_mismatch($sformatf("line_a_x got %b want %b",
                got.port_a.line_x, want.port_a.line_x));
        if (got.port_a.line_y !== want.port_a.line_y)
            report_mismatch($sformatf("line_a_y got %b want %b",
                got.port_a.line_y, want.port_a.line_y));
        if (got.port_b.line_x !== want.port_b.line_x)
            report_mismatch($sformatf("line_b_x got %b want %b",
                got.port_b.line_x, want.port_b.line_x));
        if (got.port_b.line_y !== want.port_b.line_y)
            report_mismatch($sformatf("line_b_y got %b want %b",
                got.port_b.line_y, want.port_b.line_y));
        if (got.port_a.pos_x !== want.port_a.pos_x)
            report_mismatch($sformatf("position_a_x got %0d want %0d",
                got.port_a.pos_x, want.port_a.pos_x));
        if (got.port_a.pos_y !== want.port_a.pos_y)
            report_mismatch($sformatf("position_a_y got %0d want %0d",
                got.port_a.pos_y, want.port_a.pos_y));
        if (got.port_b.pos_x !== want.port_b.pos_x)
            report_mismatch($sformatf("position_b_x got %0d want %0d",
                got.port_b.pos_x, want.port_b.pos_x));
        if (got.port_b.pos_y !== want.port_b.pos_y)
            report_mismatch($sformatf("position_b_y got %0d want %0d",
                got.port_b.pos_y, want.port_b.pos_y));
    endtask
endclass

module tb_top;
    import ape_pkg::*;

    // Length of the long receiver hold-off that fills the block up.
    localparam int HOLD_CYCLES = 80;

    // Random phases: clamp window, sender idle and receiver stall odds in
    // percent per cycle, and the number of random items to offer.
    localparam int NUM_PHASES = 7;
    localparam int PH_LO    [NUM_PHASES] = '{20,  0, 200, 0, 250, 10, 0};
    localparam int PH_HI    [NUM_PHASES] = '{53, 254, 10, 5, 254, 60, 0};
    localparam int PH_SEND  [NUM_PHASES] = '{0,  53,  0, 34,  0, 34, 0};
    localparam int PH_STALL [NUM_PHASES] = '{0,   0, 53, 34,  0, 34, 53};
    localparam int PH_ITEMS [NUM_PHASES] = '{200, 200, 200, 200, 250, 200, 200};
    localparam int PRESSURE_PHASE = 5;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic                 cfg_index = REG_POS_MIN;
    logic [POS_WIDTH-1:0] cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 kind = KIND_UPDATE;
    logic [3:0]           joy_a = '0;
    logic [3:0]           joy_b = '0;
    logic                 sense_a = 1'b1;
    logic                 sense_b = 1'b1;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic                 line_a_x;
    logic                 line_a_y;
    logic                 line_b_x;
    logic                 line_b_y;
    logic [POS_WIDTH-1:0] position_a_x;
    logic [POS_WIDTH-1:0] position_a_y;
    logic [POS_WIDTH-1:0] position_b_x;
    logic [POS_WIDTH-1:0] position_b_y;

    result_t out_item;

    // Idling odds, changed by the stimulus between phases.
    int send_idle_pct = 0;
    int stall_pct = 0;

    // The current clamp window, used to size the measurement frames.
    int cur_lo = int'(MIN_RESET);
    int cur_hi = int'(MAX_RESET);

    // The stimulus flips hold_toggle to ask for a long hold-off; the stall
    // process notices the change and counts the hold-off down on its own.
    bit hold_toggle = 1'b0;
    bit hold_seen = 1'b0;
    int hold_left = 0;

    paddle_scoreboard paddle_sb = new();

    analog_paddle_emulator u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .joy_a        (joy_a),
        .joy_b        (joy_b),
        .sense_a      (sense_a),
        .sense_b      (sense_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .line_a_x     (line_a_x),
        .line_a_y     (line_a_y),
        .line_b_x     (line_b_x),
        .line_b_y     (line_b_y),
        .position_a_x (position_a_x),
        .position_a_y (position_a_y),
        .position_b_x (position_b_x),
        .position_b_y (position_b_y)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always_comb
    begin
        out_item.port_a.line_x = line_a_x;
        out_item.port_a.line_y = line_a_y;
        out_item.port_b.line_x = line_b_x;
        out_item.port_b.line_y = line_b_y;
        out_item.port_a.pos_x  = position_a_x;
        out_item.port_a.pos_y  = position_a_y;
        out_item.port_b.pos_x  = position_b_x;
        out_item.port_b.pos_y  = position_b_y;
    end

    // Both handshakes are sampled right at the rising edge, before any of
    // the nonblocking updates of that edge land, so the values seen are the
    // ones the block saw. A result is checked before the item accepted on
    // the same edge is noted; the block's output is registered, so that
    // item's result cannot be the one on the port now.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall)
                paddle_sb.check_result(out_item);
            if (in_valid && !in_stall)
                paddle_sb.note_item(kind, joy_a, joy_b, sense_a, sense_b);
        end
    end

    // Receiver side. Normally it stalls at random with the phase's odds;
    // during a requested hold-off it stalls every cycle.
    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen) begin
            hold_seen = hold_toggle;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Offers one item and returns at the edge where it is accepted. Idle
    // cycles may come first, with the sender's valid low. Valid is raised
    // only in a later step than the one that lowered it, and when there is
    // no gap it simply stays high from the previous item.
    task automatic send_item(logic k, logic [3:0] ja, logic [3:0] jb, logic sa, logic sbv);
        if ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        kind     <= k;
        joy_a    <= ja;
        joy_b    <= jb;
        sense_a  <= sa;
        sense_b  <= sbv;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stops offering items and waits until every expected result is back.
    // The first edge lets the monitor note an item accepted just before.
    task automatic wait_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (paddle_sb.pending() != 0)
            @(posedge clk);
    endtask

    // Writes the minimum window register and then the maximum. It is only
    // called while nothing is in flight, so the scoreboard takes the new
    // window at once.
    task automatic set_window(int lo, int hi);
        cfg_we    <= 1'b1;
        cfg_index <= REG_POS_MIN;
        cfg_data  <= lo[POS_WIDTH-1:0];
        @(posedge clk);
        cfg_index <= REG_POS_MAX;
        cfg_data  <= hi[POS_WIDTH-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        paddle_sb.set_window(lo, hi);
        cur_lo = lo;
        cur_hi = hi;
    endtask

    // Random traffic. Most of it is measurement frames: both sense lines
    // high, then mostly a falling edge on one or both ports, then a run of up
    // to enough ticks to reach the latched positions, with a few joystick
    // updates and sense glitches mixed in. Now and then a frame runs past
    // the counter wrap. The rest is bursts of fully random items.
    task automatic run_random(int n);
        int sent;
        int ticks;
        int span;
        bit sa;
        bit sbv;
        sent = 0;
        while (sent < n) begin
            if ($urandom_range(99) < 25) begin
                repeat ($urandom_range(6, 1)) begin
                    send_item(1'($urandom_range(1)), 4'($urandom_range(15)),
                              4'($urandom_range(15)), 1'($urandom_range(1)),
                              1'($urandom_range(1)));
                    sent++;
                end
            end else begin
                sa  = ($urandom_range(3) == 0);
                sbv = ($urandom_range(3) == 0);
                span = ((cur_lo > cur_hi) ? cur_lo : cur_hi) + 4;
                if ($urandom_range(99) < 4)
                    ticks = $urandom_range(270, 256);
                else
                    ticks = $urandom_range(span, 0);
                send_item(1'($urandom_range(1)), 4'($urandom_range(15)),
                          4'($urandom_range(15)), 1'b1, 1'b1);
                send_item(1'($urandom_range(1)), 4'($urandom_range(15)),
                          4'($urandom_range(15)), sa, sbv);
                sent += 2;
                repeat (ticks) begin
                    send_item(($urandom_range(99) < 15) ? KIND_UPDATE : KIND_TICK,
                              4'($urandom_range(15)), 4'($urandom_range(15)),
                              sa | ($urandom_range(99) < 3),
                              sbv | ($urandom_range(99) < 3));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset window 20..53. Nothing runs yet, so a tick
        // only shows the reset state. Then up and down together cancel on port A's
        // X and port B's Y axis, and a plain step moves each axis by one.
        send_item(KIND_TICK, 4'b0000, 4'b0000, 1'b1, 1'b1);
        send_item(KIND_UPDATE, 4'b0011, 4'b1100, 1'b1, 1'b1);
        send_item(KIND_UPDATE, 4'b0101, 4'b1010, 1'b1, 1'b1);

        // A tiny window 2..3: everything clamps from above, then stepping
        // below the minimum clamps from below.
        wait_results();
        set_window(2, 3);
        send_item(KIND_UPDATE, 4'b0010, 4'b0000, 1'b1, 1'b1);
        send_item(KIND_UPDATE, 4'b1010, 4'b1000, 1'b1, 1'b1);
        send_item(KIND_UPDATE, 4'b1010, 4'b0001, 1'b1, 1'b1);
        // Falling edge on port A in an update item: the stepped positions
        // are the ones latched. Port B then falls on a tick item and must
        // not count on that item, while port A counts.
        send_item(KIND_UPDATE, 4'b0001, 4'b0000, 1'b0, 1'b1);
        send_item(KIND_TICK, 4'b0000, 4'b0000, 1'b0, 1'b0);
        repeat (4)
            send_item(KIND_TICK, 4'b0000, 4'b0000, 1'b0, 1'b0);
        // Lines stay high after their match, even with the sense lines back up.
        send_item(KIND_TICK, 4'b1111, 4'b1111, 1'b1, 1'b1);

        // Window 0..0: stepping below zero must not wrap. Port A then
        // latches zero, which the counter only reaches after a wrap.
        wait_results();
        set_window(0, 0);
        send_item(KIND_UPDATE, 4'b1010, 4'b1111, 1'b1, 1'b1);
        send_item(KIND_UPDATE, 4'b1010, 4'b1010, 1'b0, 1'b1);
        send_item(KIND_TICK, 4'b0000, 4'b0000, 1'b0, 1'b1);

        // Window at the top, 254..254.
        wait_results();
        set_window(254, 254);
        send_item(KIND_UPDATE, 4'b0101, 4'b0101, 1'b0, 1'b1);
        send_item(KIND_UPDATE, 4'b0101, 4'b0101, 1'b0, 1'b1);

        // Minimum above maximum: the minimum wins below it, the maximum elsewhere.
        wait_results();
        set_window(50, 30);
        send_item(KIND_UPDATE, 4'b0000, 4'b0000, 1'b0, 1'b1);
        send_item(KIND_UPDATE, 4'b1010, 4'b0101, 1'b0, 1'b1);
        send_item(KIND_UPDATE, 4'b0000, 4'b0000, 1'b0, 1'b1);
        send_item(KIND_TICK, 4'b0000, 4'b0000, 1'b1, 1'b1);

        // Random phases. Each one starts idle, with every result back, so
        // the window can be changed safely.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_results();
            set_window(PH_LO[ph], PH_HI[ph]);
            if (ph == PRESSURE_PHASE) begin
                // Hold the receiver off for a long stretch while the sender
                // keeps offering items back to back, so the output stage
                // fills and the block stalls its input.
                send_idle_pct = 0;
                stall_pct     = 0;
                hold_toggle   = ~hold_toggle;
                run_random(30);
            end
            send_idle_pct = PH_SEND[ph];
            stall_pct     = PH_STALL[ph];
            run_random(PH_ITEMS[ph]);
        end

        // Let everything drain, then keep clocking so that any stray result shows.
        wait_results();
        repeat (10) @(posedge clk);
        if (paddle_sb.errors == 0 && paddle_sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
